### hdl/dsc_pkg.sv
// shared types, constants and helper function of the subsequence counter
`default_nettype none

package dsc_pkg;

	// fixed widths of the channel payload fields
	localparam int SYMBOL_FIELD_W = 8;
	localparam int COUNT_FIELD_W  = 32;

	// widest symbol the command path can carry
	localparam int SYM_STORE_W    = 16;

	// default configuration
	localparam int MAX_PATTERN_DEF  = 64;
	localparam int COUNT_WIDTH_DEF  = 32;
	localparam int SYMBOL_WIDTH_DEF = 8;

	// depth of the command queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// fan-in of one level of the result readout tree
	localparam int TREE_RADIX = 8;

	// command class decided by the front end
	typedef enum logic {
		OP_PATTERN,
		OP_TEXT
	} op_t;

	// back end sequencer states
	typedef enum logic {
		BE_RUN,
		BE_DRAIN
	} be_state_t;

	// one classified command
	typedef struct packed {
		op_t                    op;
		logic [SYM_STORE_W-1:0] sym;
		logic                   first;
		logic                   last;
	} cmd_t;

	// control from the sequencer to the counter cells
	typedef struct packed {
		logic en;
		cmd_t cmd;
	} cell_ctl_t;

	// status from the counter cells
	typedef struct packed {
		logic ovf;
		logic drop;
		logic empty;
	} cell_stat_t;

	// number of registered levels in the readout tree for n leaves
	function automatic int tree_levels(input int n);
		int lv;
		int span;
		lv   = 1;
		span = TREE_RADIX;
		while (span < n) begin
			span = span * TREE_RADIX;
			lv++;
		end
		return lv;
	endfunction

endpackage

`default_nettype wire

### hdl/dsc_if.sv
// valid/ready channel interfaces for input items and results
`default_nettype none

interface dsc_item_if;
	logic                               valid;
	logic                               ready;
	logic                               kind;
	logic [dsc_pkg::SYMBOL_FIELD_W-1:0] symbol;
	logic                               first;
	logic                               last;

	modport source (output valid, kind, symbol, first, last, input ready);
	modport sink   (input valid, kind, symbol, first, last, output ready);
endinterface

interface dsc_result_if;
	logic                              valid;
	logic                              ready;
	logic [dsc_pkg::COUNT_FIELD_W-1:0] count;
	logic                              overflow;
	logic                              pattern_too_long;

	modport source (output valid, count, overflow, pattern_too_long, input ready);
	modport sink   (input valid, count, overflow, pattern_too_long, output ready);
endinterface

`default_nettype wire

### hdl/distinct_subsequence_counter.sv
// top level of the pattern subsequence counter
//
//  channel   dir  handshake     payload
//  items     in   valid/ready   kind, symbol, first, last
//  results   out  valid/ready   count, overflow, pattern_too_long
//
// pattern beats and text beats without last pass through the back end without a stall
// a text beat with last holds the back end in its drain state while the result passes
// the registered readout tree of depth L (radix 8, 2 at 64 slots)
// a result still waiting in the output register stretches the readout until it is taken
// asynchronous reset clears length, flags and all counter slots at once
// a full queue stalls the front end, which holds items.ready low once its stage is occupied
`default_nettype none

module distinct_subsequence_counter #(
	parameter int MAX_PATTERN  = dsc_pkg::MAX_PATTERN_DEF,
	parameter int COUNT_WIDTH  = dsc_pkg::COUNT_WIDTH_DEF,
	parameter int SYMBOL_WIDTH = dsc_pkg::SYMBOL_WIDTH_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	dsc_item_if.sink     items,
	dsc_result_if.source results
);

	dsc_pkg::cmd_t push_cmd;
	logic          push_valid;
	logic          push_ready;
	dsc_pkg::cmd_t pop_cmd;
	logic          pop_valid;
	logic          pop_ready;

	// accept and classify
	dsc_front #(
		.SYMBOL_WIDTH (SYMBOL_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.items      (items),
		.push_cmd   (push_cmd),
		.push_valid (push_valid),
		.push_ready (push_ready)
	);

	// decoupling queue
	dsc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_cmd   (push_cmd),
		.wr_valid (push_valid),
		.wr_ready (push_ready),
		.rd_cmd   (pop_cmd),
		.rd_valid (pop_valid),
		.rd_ready (pop_ready)
	);

	// execute and deliver
	dsc_back #(
		.MAX_PATTERN  (MAX_PATTERN),
		.COUNT_WIDTH  (COUNT_WIDTH),
		.SYMBOL_WIDTH (SYMBOL_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (pop_cmd),
		.cmd_valid (pop_valid),
		.cmd_ready (pop_ready),
		.results   (results)
	);

endmodule

`default_nettype wire

### hdl/dsc_front.sv
// front end: accepts input beats, classifies them and hands commands to the queue
`default_nettype none

module dsc_front #(
	parameter int SYMBOL_WIDTH = dsc_pkg::SYMBOL_WIDTH_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	dsc_item_if.sink           items,
	output dsc_pkg::cmd_t      push_cmd,
	output logic               push_valid,
	input  wire logic          push_ready
);

	logic                        vld_s1;
	dsc_pkg::cmd_t               cmd_s1;
	dsc_pkg::cmd_t               cmd_new;
	logic [SYMBOL_WIDTH-1:0]     sym_masked;
	logic                        accept;

	// stage is free when empty or draining this cycle
	assign items.ready = !vld_s1 || push_ready;
	assign accept      = items.valid && items.ready;

	// classify the beat, keep only the compared symbol bits
	always_comb begin
		sym_masked    = SYMBOL_WIDTH'(items.symbol);
		cmd_new.op    = items.kind ? dsc_pkg::OP_TEXT : dsc_pkg::OP_PATTERN;
		cmd_new.sym   = dsc_pkg::SYM_STORE_W'(sym_masked);
		cmd_new.first = items.first;
		// last has no meaning on pattern loads
		cmd_new.last  = items.last && items.kind;
	end

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (push_ready) begin
			vld_s1 <= 1'b0;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd_new;
		end
	end

	assign push_valid = vld_s1;
	assign push_cmd   = cmd_s1;

endmodule

`default_nettype wire

### hdl/dsc_queue.sv
// short command queue between front and back end
`default_nettype none

module dsc_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire dsc_pkg::cmd_t  wr_cmd,
	input  wire logic           wr_valid,
	output logic                wr_ready,
	output dsc_pkg::cmd_t       rd_cmd,
	output logic                rd_valid,
	input  wire logic           rd_ready
);

	localparam int DEPTH = dsc_pkg::QUEUE_DEPTH;
	localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW  = $clog2(DEPTH + 1);

	dsc_pkg::cmd_t   mem_q [DEPTH];
	logic [PW-1:0]   wptr_q;
	logic [PW-1:0]   rptr_q;
	logic [CNTW-1:0] fill_q;
	logic            do_wr;
	logic            do_rd;

	assign wr_ready = fill_q != CNTW'(DEPTH);
	assign rd_valid = fill_q != '0;
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;
	assign rd_cmd   = mem_q[rptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wr_cmd;
		end
	end

endmodule

`default_nettype wire

### hdl/dsc_cells.sv
// row of pattern/counter cells, updated in parallel from old neighbor values
`default_nettype none

module dsc_cells #(
	parameter int MAX_PATTERN  = dsc_pkg::MAX_PATTERN_DEF,
	parameter int COUNT_WIDTH  = dsc_pkg::COUNT_WIDTH_DEF,
	parameter int SYMBOL_WIDTH = dsc_pkg::SYMBOL_WIDTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire dsc_pkg::cell_ctl_t ctl,
	output logic [COUNT_WIDTH-1:0]  leaf [MAX_PATTERN],
	output dsc_pkg::cell_stat_t     stat
);

	localparam int LW = $clog2(MAX_PATTERN + 1);

	logic [SYMBOL_WIDTH-1:0] pat_q [MAX_PATTERN];
	logic [COUNT_WIDTH-1:0]  cnt_q [MAX_PATTERN];
	logic [LW-1:0]           len_q;
	logic                    ovf_q;
	logic                    drop_q;

	logic                    do_pat;
	logic                    do_text;
	logic                    first;
	logic [SYMBOL_WIDTH-1:0] sym;
	logic [LW-1:0]           base_len;
	logic                    pat_full;
	logic [MAX_PATTERN-1:0]  sat_vec;

	assign do_pat   = ctl.en && (ctl.cmd.op == dsc_pkg::OP_PATTERN);
	assign do_text  = ctl.en && (ctl.cmd.op == dsc_pkg::OP_TEXT);
	assign first    = ctl.cmd.first;
	assign sym      = ctl.cmd.sym[SYMBOL_WIDTH-1:0];
	assign base_len = first ? '0 : len_q;
	assign pat_full = base_len == LW'(MAX_PATTERN);

	// pattern length and drop flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= '0;
			drop_q <= 1'b0;
		end else if (do_pat) begin
			if (pat_full) begin
				len_q  <= base_len;
				drop_q <= 1'b1;
			end else begin
				len_q  <= base_len + 1'b1;
				drop_q <= first ? 1'b0 : drop_q;
			end
		end
	end

	// sticky saturation flag, cleared by the first text beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovf_q <= 1'b0;
		end else if (do_text) begin
			ovf_q <= (first ? 1'b0 : ovf_q) | (|sat_vec);
		end
	end

	genvar j;
	generate
		for (j = 0; j < MAX_PATTERN; j++) begin : g_cell
			logic [COUNT_WIDTH-1:0] cur;
			logic [COUNT_WIDTH-1:0] below;
			logic [COUNT_WIDTH:0]   sum;
			logic                   hit;

			// old values, seen as zero when this beat starts a new text
			always_comb begin
				cur = first ? '0 : cnt_q[j];
				if (j == 0) begin
					below = COUNT_WIDTH'(1);
				end else begin
					below = first ? '0 : cnt_q[(j == 0) ? 0 : j - 1];
				end
				sum        = {1'b0, cur} + {1'b0, below};
				hit        = (LW'(j) < len_q) && (pat_q[j] == sym);
				sat_vec[j] = hit && sum[COUNT_WIDTH];
			end

			// counter slot update with saturation
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					cnt_q[j] <= '0;
				end else if (do_text) begin
					if (hit) begin
						cnt_q[j] <= sum[COUNT_WIDTH] ? '1 : sum[COUNT_WIDTH-1:0];
					end else begin
						cnt_q[j] <= cur;
					end
				end
			end

			// pattern symbol write
			always_ff @(posedge clk) begin
				if (do_pat && !pat_full && (base_len == LW'(j))) begin
					pat_q[j] <= sym;
				end
			end

			// only the slot of the last pattern symbol feeds the readout
			assign leaf[j] = (len_q == LW'(j + 1)) ? cnt_q[j] : '0;
		end
	endgenerate

	assign stat.ovf   = ovf_q;
	assign stat.drop  = drop_q;
	assign stat.empty = len_q == '0;

endmodule

`default_nettype wire

### hdl/dsc_select.sv
// registered or-tree that picks the one live counter slot
`default_nettype none

module dsc_select #(
	parameter int N = dsc_pkg::MAX_PATTERN_DEF,
	parameter int W = dsc_pkg::COUNT_WIDTH_DEF
) (
	input  wire logic         clk,
	input  wire logic [W-1:0] leaf [N],
	output logic [W-1:0]      root
);

	localparam int R  = dsc_pkg::TREE_RADIX;
	localparam int NL = dsc_pkg::tree_levels(N);
	localparam int P  = R ** NL;

	// first node of level k in the flat node array
	function automatic int node_off(input int k);
		int acc;
		acc = 0;
		for (int i = 1; i < k; i++) begin
			acc = acc + R ** (NL - i);
		end
		return acc;
	endfunction

	localparam int TOT = node_off(NL + 1);

	logic [W-1:0] leaf_pad [P];
	logic [W-1:0] tree_q   [TOT];

	genvar i, k, n;
	generate
		// pad leaves up to a full tree
		for (i = 0; i < P; i++) begin : g_pad
			if (i < N) begin : g_live
				assign leaf_pad[i] = leaf[i];
			end else begin : g_zero
				assign leaf_pad[i] = '0;
			end
		end

		// one register level per radix step
		for (k = 1; k <= NL; k++) begin : g_lvl
			for (n = 0; n < R ** (NL - k); n++) begin : g_node
				logic [W-1:0] acc;
				if (k == 1) begin : g_leafs
					always_comb begin
						acc = '0;
						for (int c = 0; c < R; c++) begin
							acc = acc | leaf_pad[R * n + c];
						end
					end
				end else begin : g_inner
					always_comb begin
						acc = '0;
						for (int c = 0; c < R; c++) begin
							acc = acc | tree_q[node_off(k - 1) + R * n + c];
						end
					end
				end
				always_ff @(posedge clk) begin
					tree_q[node_off(k) + n] <= acc;
				end
			end
		end
	endgenerate

	assign root = tree_q[TOT - 1];

endmodule

`default_nettype wire

### hdl/dsc_back.sv
// back end: executes commands on the cell row and delivers results
`default_nettype none

module dsc_back #(
	parameter int MAX_PATTERN  = dsc_pkg::MAX_PATTERN_DEF,
	parameter int COUNT_WIDTH  = dsc_pkg::COUNT_WIDTH_DEF,
	parameter int SYMBOL_WIDTH = dsc_pkg::SYMBOL_WIDTH_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire dsc_pkg::cmd_t cmd,
	input  wire logic          cmd_valid,
	output logic               cmd_ready,
	dsc_result_if.source       results
);

	localparam int NL = dsc_pkg::tree_levels(MAX_PATTERN);
	localparam int DW = $clog2(NL + 1);

	dsc_pkg::be_state_t   state_q;
	dsc_pkg::be_state_t   state_nxt;
	dsc_pkg::cell_ctl_t   ctl;
	dsc_pkg::cell_stat_t  stat;
	logic [COUNT_WIDTH-1:0] leaf [MAX_PATTERN];
	logic [COUNT_WIDTH-1:0] root;
	logic [DW-1:0]        wait_q;
	logic                 take;
	logic                 is_result;
	logic                 out_free;
	logic                 drain_done;
	logic                 load_out;
	logic                 start_wait;

	logic                                 out_valid_q;
	logic [dsc_pkg::COUNT_FIELD_W-1:0]    count_q;
	logic                                 overflow_q;
	logic                                 too_long_q;

	dsc_cells #(
		.MAX_PATTERN  (MAX_PATTERN),
		.COUNT_WIDTH  (COUNT_WIDTH),
		.SYMBOL_WIDTH (SYMBOL_WIDTH)
	) u_cells (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.leaf   (leaf),
		.stat   (stat)
	);

	dsc_select #(
		.N (MAX_PATTERN),
		.W (COUNT_WIDTH)
	) u_select (
		.clk  (clk),
		.leaf (leaf),
		.root (root)
	);

	assign out_free   = !out_valid_q || results.ready;
	assign drain_done = (wait_q == '0) && out_free;
	assign take       = cmd_valid && cmd_ready;
	assign is_result  = (cmd.op == dsc_pkg::OP_TEXT) && cmd.last;

	assign ctl.en  = take;
	assign ctl.cmd = cmd;

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			dsc_pkg::BE_RUN: begin
				if (take && is_result) begin
					state_nxt = dsc_pkg::BE_DRAIN;
				end
			end
			dsc_pkg::BE_DRAIN: begin
				if (drain_done) begin
					state_nxt = dsc_pkg::BE_RUN;
				end
			end
			default: begin
				state_nxt = dsc_pkg::BE_RUN;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		cmd_ready  = 1'b0;
		load_out   = 1'b0;
		start_wait = 1'b0;
		unique case (state_q)
			dsc_pkg::BE_RUN: begin
				cmd_ready  = 1'b1;
				start_wait = take && is_result;
			end
			dsc_pkg::BE_DRAIN: begin
				load_out = drain_done;
			end
			default: begin
				cmd_ready = 1'b0;
			end
		endcase
	end

	// state and readout latency counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dsc_pkg::BE_RUN;
			wait_q  <= '0;
		end else begin
			state_q <= state_nxt;
			if (start_wait) begin
				wait_q <= DW'(NL);
			end else if (wait_q != '0) begin
				wait_q <= wait_q - 1'b1;
			end
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload, empty pattern counts one
	always_ff @(posedge clk) begin
		if (load_out) begin
			count_q    <= stat.empty ? dsc_pkg::COUNT_FIELD_W'(1)
			                         : dsc_pkg::COUNT_FIELD_W'(root);
			overflow_q <= stat.ovf;
			too_long_q <= stat.drop;
		end
	end

	assign results.valid            = out_valid_q;
	assign results.count            = count_q;
	assign results.overflow         = overflow_q;
	assign results.pattern_too_long = too_long_q;

endmodule

`default_nettype wire
